// ----- rtl/rkd_pkg.sv -----
package rkd_pkg;

  // Default depth of the key store.
  localparam int KEY_MAX_DEF = 256;

  // The box holds one entry for every byte value.
  localparam int BOX_DEPTH = 256;
  localparam int BOX_AW    = 8;

  // Depth of the command queue between the front and the back.
  localparam int CMD_DEPTH = 4;

  // Command classes that the front hands to the back.
  typedef enum logic [1:0] {
    OP_KEY,
    OP_KEY_LAST,
    OP_DATA
  } op_t;

  // One queued command: its class and the byte it carries.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

endpackage

// ----- rtl/rkd_ram.sv -----
module rkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rkd_front.sv -----
module rkd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          func,
  input  logic [7:0]    byte_in,
  input  logic          key_last,
  input  logic          q_full,
  output logic          push,
  output rkd_pkg::cmd_t push_cmd
);
  import rkd_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  cmd_t cmd_class;
  logic accept;

  // Classify the incoming transaction; key_last has no meaning on data.
  always_comb begin
    cmd_class.data = byte_in;
    if (func) begin
      cmd_class.op = OP_DATA;
    end else if (key_last) begin
      cmd_class.op = OP_KEY_LAST;
    end else begin
      cmd_class.op = OP_KEY;
    end
  end

  // The stage moves into the queue whenever the queue has room.
  assign push     = cmd_valid && !q_full;
  assign push_cmd = cmd;
  assign in_stall = cmd_valid && q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (push) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_class;
    end
  end

  // A held command that cannot move must keep blocking new transactions.
  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !push) |=> cmd_valid)
    else $error("front stage lost a command");

  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && q_full) |=> $stable(cmd))
    else $error("front stage changed while the queue was full");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> cmd_valid)
    else $error("accepted transaction did not reach the front stage");

endmodule

// ----- rtl/rkd_cmd_fifo.sv -----
module rkd_cmd_fifo #(
  parameter int DEPTH = rkd_pkg::CMD_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rkd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output rkd_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import rkd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("command queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into a full command queue");

  assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from an empty command queue");

endmodule

// ----- rtl/rkd_back.sv -----
module rkd_back #(
  parameter int KEY_MAX = rkd_pkg::KEY_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  rkd_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    plain_byte
);
  import rkd_pkg::*;

  localparam int KA = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int CW = $clog2(KEY_MAX + 1);
  localparam logic [BOX_AW-1:0] IdxLast = BOX_AW'(BOX_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RD,
    S_MIX,
    S_SWAP_A,
    S_SWAP_B,
    S_D1,
    S_D2,
    S_D3,
    S_OUT
  } state_t;

  state_t            state;
  logic [CW-1:0]     key_count;
  logic [CW-1:0]     sched_len;
  logic [BOX_AW-1:0] stream_pos;
  logic [BOX_AW-1:0] idx;
  logic [BOX_AW-1:0] acc;
  logic [BOX_AW-1:0] held;
  logic [BOX_AW-1:0] bj;
  logic [KA-1:0]     kidx;
  logic [7:0]        byte_q;
  logic [7:0]        result;

  logic              box_we;
  logic [BOX_AW-1:0] box_waddr;
  logic [7:0]        box_wdata;
  logic [BOX_AW-1:0] box_raddr;
  logic [7:0]        box_rdata;
  logic              key_we;
  logic [KA-1:0]     key_raddr;
  logic [7:0]        key_rdata;

  logic              key_room;
  logic [BOX_AW-1:0] pos_next;
  logic [BOX_AW-1:0] acc_next;
  logic              kidx_wrap;
  logic              slot_free;

  assign key_room  = (key_count < CW'(KEY_MAX));
  assign pos_next  = stream_pos + BOX_AW'(1);
  assign acc_next  = box_rdata + acc + key_rdata;
  assign kidx_wrap = ((CW'(kidx) + CW'(1)) >= sched_len);
  assign slot_free = !out_valid || !out_stall;
  assign pop       = (state == S_IDLE) && !q_empty;
  assign key_we    = pop && (q_cmd.op != OP_DATA) && key_room;

  // Box and key store addressing for each step of the sequencer.
  always_comb begin
    box_we    = 1'b0;
    box_waddr = idx;
    box_wdata = idx;
    box_raddr = pos_next;
    key_raddr = kidx;
    unique case (state)
      S_IDLE:   box_raddr = pos_next;
      S_INIT:   box_we = 1'b1;
      S_RD:     box_raddr = idx;
      S_MIX:    box_raddr = acc_next;
      S_SWAP_A: begin
        box_we    = 1'b1;
        box_wdata = box_rdata;
      end
      S_SWAP_B: begin
        box_we    = 1'b1;
        box_waddr = acc;
        box_wdata = held;
      end
      S_D1:     box_raddr = box_rdata + stream_pos;
      S_D2:     box_raddr = bj + box_rdata;
      default:  box_raddr = pos_next;
    endcase
  end

  rkd_ram #(
    .WIDTH (8),
    .DEPTH (BOX_DEPTH)
  ) u_box (
    .clk   (clk),
    .we    (box_we),
    .waddr (box_waddr),
    .wdata (box_wdata),
    .raddr (box_raddr),
    .rdata (box_rdata)
  );

  rkd_ram #(
    .WIDTH (8),
    .DEPTH (KEY_MAX)
  ) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_count[KA-1:0]),
    .wdata (q_cmd.data),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // Sequencer: key loading, box schedule, and the three-read data path.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      key_count  <= '0;
      stream_pos <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one lands in it.
      if (out_valid && !out_stall && state != S_D3 && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (q_cmd.op == OP_DATA) begin
              byte_q     <= q_cmd.data;
              stream_pos <= pos_next;
              state      <= S_D1;
            end else if (q_cmd.op == OP_KEY_LAST) begin
              sched_len  <= key_room ? key_count + CW'(1) : key_count;
              key_count  <= '0;
              stream_pos <= '0;
              idx        <= '0;
              state      <= S_INIT;
            end else if (key_room) begin
              key_count <= key_count + CW'(1);
            end
          end
        end
        S_INIT: begin
          idx <= idx + BOX_AW'(1);
          if (idx == IdxLast) begin
            acc   <= '0;
            kidx  <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_MIX;
        end
        S_MIX: begin
          acc   <= acc_next;
          held  <= box_rdata;
          kidx  <= kidx_wrap ? '0 : kidx + KA'(1);
          state <= S_SWAP_A;
        end
        S_SWAP_A: begin
          state <= S_SWAP_B;
        end
        S_SWAP_B: begin
          idx   <= idx + BOX_AW'(1);
          state <= (idx == IdxLast) ? S_IDLE : S_RD;
        end
        S_D1: begin
          bj    <= box_rdata;
          state <= S_D2;
        end
        S_D2: begin
          state <= S_D3;
        end
        S_D3: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            plain_byte <= byte_q ^ box_rdata;
            state      <= S_IDLE;
          end else begin
            result <= byte_q ^ box_rdata;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            plain_byte <= result;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    key_count <= CW'(KEY_MAX))
    else $error("key count beyond key store depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (sched_len != '0))
    else $error("schedule running with an empty key");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_D3 || $past(state) == S_OUT))
    else $error("result produced outside the data path");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_MIX) |-> (CW'(kidx) < sched_len))
    else $error("key index outside the loaded key");

endmodule

// ----- rtl/rc4_keybox_stream_decrypt_top.sv -----
// A key transaction is stored from the engine's idle state; a last key byte starts a schedule
// that sets the box to identity and then runs swap steps of read, mix, swap A and swap B.
// A data byte runs the states D1 to D3 (three dependent reads of the single-read-port box
// RAM plus the XOR); the result is registered in plain_byte.
// The engine takes no new data byte until the last one has passed the box RAM read chain.
// Synchronous reset clears the control state; box and key store contents stay undefined.
module rc4_keybox_stream_decrypt_top #(
  parameter int KEY_MAX = rkd_pkg::KEY_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] byte_in,
  input  logic       key_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] plain_byte
);
  import rkd_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t pop_cmd;

  // Front: accept and classify input transactions.
  rkd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .byte_in  (byte_in),
    .key_last (key_last),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Queue that decouples the front from the engine.
  rkd_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // Back: key store, box schedule and decryption.
  rkd_back #(
    .KEY_MAX (KEY_MAX)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .plain_byte (plain_byte)
  );

endmodule

// ----- verif/rc4_keybox_stream_decrypt_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the key box decryptor. It keeps its own key store and box,
// predicts the plain byte for every accepted data transaction and compares each
// accepted result with the oldest prediction.
module rc4_keybox_stream_decrypt_checker #(
  parameter int   KEY_MAX   = rkd_pkg::KEY_MAX_DEF,
  parameter logic FUNC_DATA = 1'b1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        func,
  input  logic [7:0]  byte_in,
  input  logic        key_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  plain_byte,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned bytes_checked,
  output int unsigned schedules_run,
  output int unsigned key_bytes_dropped
);

  logic [7:0]  key_mem [KEY_MAX];
  logic [7:0]  box_mem [rkd_pkg::BOX_DEPTH];
  int unsigned key_len;
  logic [7:0]  pos;
  logic [7:0]  plain_due_q [$];
  logic [7:0]  want;

  // Run the key schedule over the held key bytes, then start a fresh key and stream.
  function automatic void schedule_box();
    int unsigned kidx;
    logic [7:0]  acc;
    logic [7:0]  held;
    kidx = 0;
    acc  = 8'h00;
    for (int i = 0; i < rkd_pkg::BOX_DEPTH; i++) box_mem[i] = i[7:0];
    for (int i = 0; i < rkd_pkg::BOX_DEPTH; i++) begin
      held = box_mem[i];
      acc  = held + acc + key_mem[kidx];
      kidx++;
      if (kidx >= key_len) kidx = 0;
      box_mem[i]   = box_mem[acc];
      box_mem[acc] = held;
    end
    pos     = 8'h00;
    key_len = 0;
  endfunction

  // Three dependent box reads give the keystream byte; the stream position advances.
  function automatic logic [7:0] keystream_byte();
    logic [7:0] j;
    logic [7:0] bj;
    logic [7:0] inner_idx;
    logic [7:0] inner;
    logic [7:0] outer_idx;
    j         = pos + 8'd1;
    bj        = box_mem[j];
    inner_idx = bj + j;
    inner     = box_mem[inner_idx];
    outer_idx = bj + inner;
    pos       = j;
    return box_mem[outer_idx];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key_len           = 0;
      pos               = 8'h00;
      plain_due_q.delete();
      mismatches        = 0;
      bytes_checked     = 0;
      schedules_run     = 0;
      key_bytes_dropped = 0;
    end else begin
      // Input transaction: update the key store or predict a plain byte.
      if (in_valid && !in_stall) begin
        if (func == FUNC_DATA) begin
          plain_due_q.push_back(byte_in ^ keystream_byte());
        end else begin
          if (key_len < KEY_MAX) begin
            key_mem[key_len] = byte_in;
            key_len++;
          end else begin
            key_bytes_dropped++;
          end
          if (key_last) begin
            schedule_box();
            schedules_run++;
          end
        end
      end

      // Result transaction: compare with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (plain_due_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t ns: plain_byte %02h arrived with no data transaction pending",
                     $time, plain_byte);
          mismatches++;
        end else begin
          want = plain_due_q.pop_front();
          bytes_checked++;
          if (plain_byte !== want) begin
            if (mismatches < 10)
              $display("%0t ns: plain_byte mismatch, expected %02h, got %02h",
                       $time, want, plain_byte);
            mismatches++;
          end
        end
      end
    end
    outstanding = plain_due_q.size();
  end

endmodule

// ----- verif/rc4_keybox_stream_decrypt_top_tb.sv -----
`timescale 1ns / 1ps

module rc4_keybox_stream_decrypt_top_tb;

  localparam logic        FUNC_KEY     = 1'b0;
  localparam logic        FUNC_DATA    = 1'b1;
  localparam int unsigned ITEM_TARGET  = 1920;
  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned DRAIN_TAIL   = 24;
  localparam int unsigned PACE_SPAN    = 96;

  // Traffic shapes that rotate through the run.
  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SLOW_SOURCE,
    PACE_SLOW_SINK,
    PACE_BOTH_SLOW
  } pace_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       func      = FUNC_KEY;
  logic [7:0] byte_in   = 8'h00;
  logic       key_last  = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] plain_byte;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned drain_cycles;
  int unsigned seq;
  int unsigned pick;
  int unsigned key_len;
  int unsigned run_len;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned bytes_checked;
  int unsigned schedules_run;
  int unsigned key_bytes_dropped;

  rc4_keybox_stream_decrypt_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .byte_in    (byte_in),
    .key_last   (key_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .plain_byte (plain_byte)
  );

  rc4_keybox_stream_decrypt_checker #(
    .FUNC_DATA (FUNC_DATA)
  ) u_check (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .func              (func),
    .byte_in           (byte_in),
    .key_last          (key_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .plain_byte        (plain_byte),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .bytes_checked     (bytes_checked),
    .schedules_run     (schedules_run),
    .key_bytes_dropped (key_bytes_dropped)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random with the current pace.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: too many cycles in a row without any transaction ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Pick the traffic shape from how far the run has come.
  task automatic select_pace();
    pace_t pace;
    pace = pace_t'((items_sent / PACE_SPAN) % 4);
    case (pace)
      PACE_FULL: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      PACE_SLOW_SOURCE: begin
        idle_pct  = 72;
        stall_pct = 0;
      end
      PACE_SLOW_SINK: begin
        idle_pct  = 0;
        stall_pct = 72;
      end
      default: begin
        idle_pct  = 25;
        stall_pct = 25;
      end
    endcase
  endtask

  // Offer one input transaction, idling first at random, and hold it until accepted.
  task automatic send_item(input logic f, input logic [7:0] b, input logic kl);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      func     <= 1'($urandom_range(1));
      byte_in  <= 8'($urandom_range(255));
      key_last <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    byte_in  <= b;
    key_last <= kl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    select_pace();
  endtask

  // A run of cipher bytes; now and then key_last is set, which the block ignores on data.
  task automatic send_data(input int unsigned n);
    for (int unsigned k = 0; k < n; k++)
      send_item(FUNC_DATA, 8'($urandom_range(255)), ($urandom_range(99) < 8));
  endtask

  // A key of the given length; a few data bytes may slip in between its bytes.
  task automatic send_key(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      if (k != 0 && $urandom_range(99) < 6) send_data($urandom_range(4, 1));
      send_item(FUNC_KEY, 8'($urandom_range(255)), (k == len - 1));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: one-byte zero key, extreme data bytes, key_last on a data byte.
    send_item(FUNC_KEY,  8'h00, 1'b1);
    send_item(FUNC_DATA, 8'h00, 1'b0);
    send_item(FUNC_DATA, 8'hFF, 1'b1);
    send_item(FUNC_DATA, 8'h55, 1'b0);
    send_item(FUNC_DATA, 8'hAA, 1'b0);
    // A three-byte key with extreme values.
    send_item(FUNC_KEY,  8'hFF, 1'b0);
    send_item(FUNC_KEY,  8'h80, 1'b0);
    send_item(FUNC_KEY,  8'h01, 1'b1);
    send_data(4);
    // Part of the next key arrives while the old stream still runs.
    send_item(FUNC_KEY,  8'h12, 1'b0);
    send_data(3);
    send_item(FUNC_KEY,  8'h34, 1'b1);
    send_data(2);
    // Single all-ones key, then back-to-back key schedule and data.
    send_item(FUNC_KEY,  8'hFF, 1'b1);
    send_item(FUNC_DATA, 8'hFF, 1'b0);

    // Random: keys of mixed length followed by data runs; one key overflows the store
    // and one fills it exactly.
    seq = 0;
    while (items_sent < ITEM_TARGET) begin
      seq++;
      pick = $urandom_range(99);
      if (seq == 2)
        key_len = rkd_pkg::KEY_MAX_DEF + $urandom_range(12, 1);
      else if (seq == 5)
        key_len = rkd_pkg::KEY_MAX_DEF;
      else if (pick < 20)
        key_len = $urandom_range(40, 9);
      else
        key_len = $urandom_range(8, 1);
      send_key(key_len);

      pick = $urandom_range(99);
      if (pick < 10)
        run_len = 0;
      else if (pick < 15)
        run_len = $urandom_range(320, 260);
      else
        run_len = $urandom_range(48, 1);
      send_data(run_len);
    end

    // Drain with no stalls until every predicted byte has come back.
    stall_pct = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (outstanding != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (DRAIN_TAIL) @(negedge clk);

    $display("Sent %0d input transactions, ran %0d key schedules, dropped %0d key bytes",
             items_sent, schedules_run, key_bytes_dropped);
    $display("Checked %0d plain bytes: %0d mismatches, %0d still outstanding",
             bytes_checked, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rkd_pkg.sv
rtl/rkd_ram.sv
rtl/rkd_front.sv
rtl/rkd_cmd_fifo.sv
rtl/rkd_back.sv
rtl/rc4_keybox_stream_decrypt_top.sv
verif/rc4_keybox_stream_decrypt_checker.sv
verif/rc4_keybox_stream_decrypt_top_tb.sv
